// ===== design/meaf_pkg.sv =====
`timescale 1ns / 1ps

package meaf_pkg;

  localparam int DataW = 32;
  localparam int ImmW = 16;
  localparam int DivBitsPerStage = 2;
  localparam int DivStages = DataW / DivBitsPerStage;

  localparam logic [5:0] OpcRtype = 6'h00;
  localparam logic [5:0] OpcJ     = 6'h02;
  localparam logic [5:0] OpcBeq   = 6'h04;
  localparam logic [5:0] OpcBlez  = 6'h06;
  localparam logic [5:0] OpcBgtz  = 6'h07;
  localparam logic [5:0] OpcAddi  = 6'h08;
  localparam logic [5:0] OpcLw    = 6'h23;
  localparam logic [5:0] OpcSw    = 6'h2B;
  localparam logic [5:0] FnMult   = 6'h18;
  localparam logic [5:0] FnDiv    = 6'h1A;
  localparam logic [5:0] FnAdd    = 6'h20;
  localparam logic [5:0] FnSub    = 6'h22;

  localparam logic [1:0] SrcDecoded = 2'd0;
  localparam logic [1:0] SrcReread  = 2'd1;
  localparam logic [1:0] SrcForward = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE, OP_ADD, OP_SUB, OP_MULT, OP_DIV, OP_ADDI, OP_MEM,
    OP_BGTZ, OP_BLEZ, OP_BEQ, OP_J
  } op_t;

  typedef struct packed {
    logic             valid;
    op_t              op;
    logic [DataW-1:0] rs;
    logic [DataW-1:0] rt;
    logic [ImmW-1:0]  imm;
  } dec_t;

  typedef struct packed {
    logic             valid;
    logic             is_div;
    logic             neg;
    logic             dz;
    logic [DataW-1:0] res;
    logic             wr;
    logic [DataW-1:0] addr;
    logic             taken;
    logic [ImmW-1:0]  tgt;
  } ex_t;

  typedef struct packed {
    ex_t              ctl;
    logic [DataW-1:0] rem;
    logic [DataW-1:0] num;
    logic [DataW-1:0] den;
  } div_work_t;

  function automatic logic [DataW-1:0] pick_operand(logic [1:0] sel, logic [DataW-1:0] dec,
      logic [DataW-1:0] rer, logic [DataW-1:0] fwd, logic stall2);
    logic [DataW-1:0] v;
    case (sel)
      SrcReread:  v = rer;
      SrcForward: v = stall2 ? rer : fwd;
      default:    v = dec;
    endcase
    return v;
  endfunction

  function automatic op_t decode_op(logic [5:0] opcode, logic [5:0] funct);
    op_t o;
    case (opcode)
      OpcRtype: begin
        case (funct)
          FnAdd:   o = OP_ADD;
          FnSub:   o = OP_SUB;
          FnMult:  o = OP_MULT;
          FnDiv:   o = OP_DIV;
          default: o = OP_NONE;
        endcase
      end
      OpcLw, OpcSw: o = OP_MEM;
      OpcAddi:      o = OP_ADDI;
      OpcBgtz:      o = OP_BGTZ;
      OpcBlez:      o = OP_BLEZ;
      OpcBeq:       o = OP_BEQ;
      OpcJ:         o = OP_J;
      default:      o = OP_NONE;
    endcase
    return o;
  endfunction

  function automatic div_work_t div_step(div_work_t w);
    div_work_t o;
    logic [DataW:0] t;
    logic [DataW:0] diff;
    o = w;
    for (int i = 0; i < DivBitsPerStage; i++) begin
      t = {o.rem, o.num[DataW-1]};
      o.num = {o.num[DataW-2:0], 1'b0};
      diff = t - {1'b0, o.den};
      if (t >= {1'b0, o.den}) begin
        o.rem = diff[DataW-1:0];
        o.num[0] = 1'b1;
      end else begin
        o.rem = t[DataW-1:0];
      end
    end
    return o;
  endfunction

endpackage

// ===== design/meaf_if.sv =====
`timescale 1ns / 1ps

interface meaf_instr_if;
  logic        valid;
  logic        ready;
  logic [5:0]  opcode;
  logic [5:0]  funct;
  logic signed [31:0] rs_decoded;
  logic signed [31:0] rt_decoded;
  logic signed [31:0] rs_reread;
  logic signed [31:0] rt_reread;
  logic signed [31:0] rs_forwarded;
  logic signed [31:0] rt_forwarded;
  logic [1:0]  rs_source;
  logic [1:0]  rt_source;
  logic        after_load_stall;
  logic signed [15:0] immediate;

  modport source (output valid, opcode, funct, rs_decoded, rt_decoded, rs_reread, rt_reread,
    rs_forwarded, rt_forwarded, rs_source, rt_source, after_load_stall, immediate,
    input ready);
  modport sink (input valid, opcode, funct, rs_decoded, rt_decoded, rs_reread, rt_reread,
    rs_forwarded, rt_forwarded, rs_source, rt_source, after_load_stall, immediate,
    output ready);
endinterface

interface meaf_result_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] result_value;
  logic        result_written;
  logic signed [31:0] effective_address;
  logic        branch_taken;
  logic signed [15:0] branch_target;
  logic        divide_by_zero;

  modport source (output valid, result_value, result_written, effective_address,
    branch_taken, branch_target, divide_by_zero, input ready);
  modport sink (input valid, result_value, result_written, effective_address,
    branch_taken, branch_target, divide_by_zero, output ready);
endinterface

// ===== design/meaf_decode.sv =====
`timescale 1ns / 1ps

module meaf_decode (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  meaf_instr_if.sink       instr,
  output meaf_pkg::dec_t   dec
);

  assign instr.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      dec.valid <= 1'b0;
    end else if (en) begin
      dec.valid <= instr.valid;
    end
    if (en) begin
      dec.op  <= meaf_pkg::decode_op(instr.opcode, instr.funct);
      dec.rs  <= meaf_pkg::pick_operand(instr.rs_source, instr.rs_decoded, instr.rs_reread,
                   instr.rs_forwarded, instr.after_load_stall);
      dec.rt  <= meaf_pkg::pick_operand(instr.rt_source, instr.rt_decoded, instr.rt_reread,
                   instr.rt_forwarded, instr.after_load_stall);
      dec.imm <= instr.immediate;
    end
  end

endmodule

// ===== design/meaf_alu.sv =====
`timescale 1ns / 1ps

module meaf_alu (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  meaf_pkg::dec_t       dec,
  output meaf_pkg::div_work_t  work
);

  meaf_pkg::ex_t ex_next;
  logic [meaf_pkg::DataW-1:0] imm_ext;
  logic [meaf_pkg::DataW-1:0] rs_mag;
  logic [meaf_pkg::DataW-1:0] rt_mag;
  logic rs_neg;
  logic rs_zero;

  assign imm_ext = {{(meaf_pkg::DataW - meaf_pkg::ImmW){dec.imm[meaf_pkg::ImmW-1]}}, dec.imm};
  assign rs_neg  = dec.rs[meaf_pkg::DataW-1];
  assign rs_zero = (dec.rs == '0);
  assign rs_mag  = rs_neg ? (~dec.rs + 1'b1) : dec.rs;
  assign rt_mag  = dec.rt[meaf_pkg::DataW-1] ? (~dec.rt + 1'b1) : dec.rt;

  always_comb begin
    ex_next        = '0;
    ex_next.valid  = dec.valid;
    ex_next.neg    = rs_neg ^ dec.rt[meaf_pkg::DataW-1];
    case (dec.op)
      meaf_pkg::OP_ADD: begin
        ex_next.res = dec.rs + dec.rt;
        ex_next.wr  = 1'b1;
      end
      meaf_pkg::OP_SUB: begin
        ex_next.res = dec.rs - dec.rt;
        ex_next.wr  = 1'b1;
      end
      meaf_pkg::OP_MULT: begin
        ex_next.res = dec.rs * dec.rt;
        ex_next.wr  = 1'b1;
      end
      meaf_pkg::OP_DIV: begin
        ex_next.is_div = 1'b1;
        ex_next.dz     = (dec.rt == '0);
        ex_next.wr     = (dec.rt != '0);
      end
      meaf_pkg::OP_ADDI: begin
        ex_next.res = dec.rs + imm_ext;
        ex_next.wr  = 1'b1;
      end
      meaf_pkg::OP_MEM:  ex_next.addr  = dec.rs + imm_ext;
      meaf_pkg::OP_BGTZ: ex_next.taken = !rs_neg && !rs_zero;
      meaf_pkg::OP_BLEZ: ex_next.taken = rs_neg || rs_zero;
      meaf_pkg::OP_BEQ:  ex_next.taken = (dec.rs == dec.rt);
      meaf_pkg::OP_J:    ex_next.taken = 1'b1;
      default: ;
    endcase
    ex_next.tgt = ex_next.taken ? dec.imm : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      work.ctl.valid <= 1'b0;
    end else if (en) begin
      work.ctl.valid <= ex_next.valid;
    end
    if (en) begin
      work.ctl.is_div <= ex_next.is_div;
      work.ctl.neg    <= ex_next.neg;
      work.ctl.dz     <= ex_next.dz;
      work.ctl.res    <= ex_next.res;
      work.ctl.wr     <= ex_next.wr;
      work.ctl.addr   <= ex_next.addr;
      work.ctl.taken  <= ex_next.taken;
      work.ctl.tgt    <= ex_next.tgt;
      work.rem        <= '0;
      work.num        <= rs_mag;
      work.den        <= rt_mag;
    end
  end

endmodule

// ===== design/meaf_divider.sv =====
`timescale 1ns / 1ps

module meaf_divider (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  meaf_pkg::div_work_t  work,
  output meaf_pkg::div_work_t  done
);

  meaf_pkg::div_work_t stage [meaf_pkg::DivStages];

  for (genvar k = 0; k < meaf_pkg::DivStages; k++) begin : g_stage
    meaf_pkg::div_work_t step_in;
    meaf_pkg::div_work_t step_out;

    if (k == 0) begin : g_first
      assign step_in = work;
    end else begin : g_rest
      assign step_in = stage[k-1];
    end

    assign step_out = meaf_pkg::div_step(step_in);

    always_ff @(posedge clk) begin
      if (rst) begin
        stage[k] <= '0;
      end else if (en) begin
        stage[k] <= step_out;
      end
    end
  end

  assign done = stage[meaf_pkg::DivStages-1];

endmodule

// ===== design/mips_execute_alu_forwarding.sv =====
`timescale 1ns / 1ps

// Execute stage: operand selection with forwarding, then add, sub, mult, signed div, addi,
// load/store address and branch resolution. One instruction request is accepted per clock unless
// the pipeline is held; each passes through the decode and ALU registers, sixteen radix-4
// divider stages that every instruction passes through, and the output register. The whole
// pipeline advances together and holds while a finished result waits to be taken.

module mips_execute_alu_forwarding (
  input  logic           clk,
  input  logic           rst,
  meaf_instr_if.sink     instr,
  meaf_result_if.source  result
);

  logic en;
  meaf_pkg::dec_t dec;
  meaf_pkg::div_work_t work;
  meaf_pkg::div_work_t done;
  logic [meaf_pkg::DataW-1:0] res_next;

  assign en = !result.valid || result.ready;

  meaf_decode u_decode (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .instr (instr),
    .dec   (dec)
  );

  meaf_alu u_alu (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .dec  (dec),
    .work (work)
  );

  meaf_divider u_divider (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .work (work),
    .done (done)
  );

  always_comb begin
    res_next = done.ctl.res;
    if (done.ctl.is_div) begin
      if (done.ctl.dz) begin
        res_next = '0;
      end else begin
        res_next = done.ctl.neg ? (~done.num + 1'b1) : done.num;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (en) begin
      result.valid <= done.ctl.valid;
    end
    if (en) begin
      result.result_value      <= res_next;
      result.result_written    <= done.ctl.wr;
      result.effective_address <= done.ctl.addr;
      result.branch_taken      <= done.ctl.taken;
      result.branch_target     <= done.ctl.tgt;
      result.divide_by_zero    <= done.ctl.dz;
    end
  end

  a_dz_no_write: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.divide_by_zero |-> !result.result_written && !result.branch_taken)
    else $error("divide by zero delivered a result or branch");

  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.result_written |-> result.result_value == '0)
    else $error("unwritten result is not zero");

  a_not_taken_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.branch_taken |-> result.branch_target == '0)
    else $error("branch target set without a taken branch");

endmodule
